@@ rtl/apr_pkg.sv @@
// Shared constants, register indexes and sequencer states of the averaged P regulator.
package apr_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int OUTPUT_MAX  = 4000;
  localparam int TALLY_BITS  = 16;
  localparam int SUM_BITS    = SAMPLE_BITS + TALLY_BITS;

  localparam int TARGET_BITS = 12;
  localparam int GAIN_BITS   = 16;
  localparam int COUNT_BITS  = 16;
  localparam int CFG_BITS    = 16;
  localparam int INDEX_BITS  = 2;

  localparam int IN_FIELD_BITS = 12;
  localparam int DRIVE_BITS    = 12;
  localparam int MEAN_BITS     = 12;
  localparam int ERR_BITS      = 21;
  localparam int IN_DATA_BITS  = 16;
  localparam int OUT_DATA_BITS = 48;

  localparam int DIFF_BITS = ((SAMPLE_BITS > TARGET_BITS) ? SAMPLE_BITS : TARGET_BITS) + 1;
  localparam int PROD_BITS = GAIN_BITS + 1 + DIFF_BITS;
  localparam int FRAC_BITS = 8;
  localparam int DIV_CNT_BITS = $clog2(SAMPLE_BITS);

  localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(1000);

  typedef logic [INDEX_BITS-1:0] reg_index_t;
  localparam reg_index_t REG_TARGET = 2'd0;
  localparam reg_index_t REG_GAIN   = 2'd1;
  localparam reg_index_t REG_COUNT  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_ERR,
    ST_DRIVE
  } state_t;

endpackage

@@ rtl/averaged_p_regulator.sv @@
// Averaged proportional regulator: boxcar mean of converter samples and a Q8.8 P-term.
//
// Usage
//   s_tvalid/s_tready/s_tdata carry converter samples, adc_sample in s_tdata[11:0].
//   Each sample is added into a running sum; once the tally reaches average_count
//   (0 counts as 1) the batch closes and one result transaction is produced on
//   m_tvalid/m_tready/m_tdata/m_tuser: drive_code, mean_sample and error_term in
//   m_tdata, the clamp flag in m_tuser. Other samples produce nothing.
//   cfg_we/cfg_index/cfg_wdata write target_code (0), gain_q8_8 (1) and
//   average_count (2); a write leaves the running sum alone.
// Sequence
//   A sample that does not close a batch leaves s_tready high.
//   The closing sample runs the mean through a restoring divider, one quotient
//   bit per cycle for SAMPLE_BITS (12) quotient bits, then the multiply, the
//   scaling and the clamp steps in turn: s_tready stays low until the clamp step
//   has loaded the result into the output register.
// Reset and stalls
//   rst (synchronous) clears the sum, the tally and the output valid flag and sets
//   target 0, gain 0, count 1000. A stalled receiver holds the result in the
//   output register; sampling carries on, and only a second finished batch waits
//   in the clamp step until the register is free.
module averaged_p_regulator (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [apr_pkg::INDEX_BITS-1:0]      cfg_index,
  input  logic [apr_pkg::CFG_BITS-1:0]        cfg_wdata,
  // sample stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [apr_pkg::IN_DATA_BITS-1:0]    s_tdata,   // [11:0] adc_sample
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [apr_pkg::OUT_DATA_BITS-1:0]   m_tdata,   // [11:0] drive_code,
                                                         // [23:12] mean_sample,
                                                         // [44:24] error_term
  output logic                                m_tuser    // [0] saturated
);

  // Configuration registers
  logic [apr_pkg::TARGET_BITS-1:0] target_code;
  logic [apr_pkg::GAIN_BITS-1:0]   gain_q8_8;
  logic [apr_pkg::COUNT_BITS-1:0]  average_count;

  // Accumulator state
  logic [apr_pkg::SUM_BITS-1:0]    sample_sum;
  logic [apr_pkg::TALLY_BITS-1:0]  sample_tally;

  // Sequencer and datapath registers
  apr_pkg::state_t                     state, state_next;
  logic [apr_pkg::TALLY_BITS-1:0]      div_rem;
  logic [apr_pkg::SAMPLE_BITS-1:0]     div_quo;
  logic [apr_pkg::DIV_CNT_BITS-1:0]    div_cnt;
  logic                                div_zero;
  logic signed [apr_pkg::PROD_BITS-1:0] prod;
  logic signed [apr_pkg::ERR_BITS-1:0]  err;

  // Output register
  logic [apr_pkg::DRIVE_BITS-1:0]  out_drive;
  logic [apr_pkg::MEAN_BITS-1:0]   out_mean;
  logic [apr_pkg::ERR_BITS-1:0]    out_err;
  logic                            out_sat;

  // Control from the sequencer
  logic in_take;      // sample transaction this cycle
  logic div_step;     // one restoring divide step
  logic mul_load;
  logic err_load;
  logic out_load;

  // Sample accumulation
  logic [apr_pkg::SAMPLE_BITS-1:0] sample;
  logic [apr_pkg::SUM_BITS-1:0]    sum_new;
  logic [apr_pkg::TALLY_BITS-1:0]  tally_new;
  logic [apr_pkg::COUNT_BITS-1:0]  need;
  logic                            batch_end;

  assign sample    = s_tdata[apr_pkg::SAMPLE_BITS-1:0];
  assign sum_new   = sample_sum + apr_pkg::SUM_BITS'(sample);
  assign tally_new = sample_tally + apr_pkg::TALLY_BITS'(1);
  assign need      = (average_count == '0) ? apr_pkg::COUNT_BITS'(1) : average_count;
  assign batch_end = (tally_new == '0) || (tally_new >= need);

  // Trial subtractor of the restoring divider; remainder stays below the tally
  logic [apr_pkg::TALLY_BITS+1:0]  div_trial;
  logic                            div_ok;
  logic [apr_pkg::SAMPLE_BITS-1:0] mean;

  assign div_trial = {1'b0, div_rem, div_quo[apr_pkg::SAMPLE_BITS-1]}
                   - {2'b00, sample_tally};
  assign div_ok    = !div_trial[apr_pkg::TALLY_BITS+1];
  assign mean      = div_zero ? '0 : div_quo;

  // Error: gain * (target - mean), scaled by 1/256 toward zero, then range-limited
  logic signed [apr_pkg::DIFF_BITS-1:0] diff;
  logic [apr_pkg::PROD_BITS-1:0]        mag;
  logic [apr_pkg::PROD_BITS-1:0]        mag_sh;
  logic signed [apr_pkg::ERR_BITS-1:0]  err_next;
  localparam logic [apr_pkg::PROD_BITS-1:0] ERR_POS_LIM =
    apr_pkg::PROD_BITS'((1 << (apr_pkg::ERR_BITS - 1)) - 1);
  localparam logic [apr_pkg::PROD_BITS-1:0] ERR_NEG_LIM =
    apr_pkg::PROD_BITS'(1 << (apr_pkg::ERR_BITS - 1));

  assign diff = $signed(apr_pkg::DIFF_BITS'(target_code)) - $signed(apr_pkg::DIFF_BITS'(mean));
  assign mag    = prod[apr_pkg::PROD_BITS-1] ? apr_pkg::PROD_BITS'(-prod)
                                             : apr_pkg::PROD_BITS'(prod);
  assign mag_sh = mag >> apr_pkg::FRAC_BITS;

  always_comb begin
    if (prod[apr_pkg::PROD_BITS-1]) begin
      if (mag_sh > ERR_NEG_LIM) begin
        err_next = $signed(apr_pkg::ERR_BITS'(ERR_NEG_LIM));
      end else begin
        err_next = $signed(apr_pkg::ERR_BITS'(-mag_sh));
      end
    end else begin
      if (mag_sh > ERR_POS_LIM) begin
        err_next = $signed(apr_pkg::ERR_BITS'(ERR_POS_LIM));
      end else begin
        err_next = $signed(apr_pkg::ERR_BITS'(mag_sh));
      end
    end
  end

  // Drive: target + error, clamped to 0..OUTPUT_MAX
  localparam int DRIVE_SUM_BITS = apr_pkg::ERR_BITS + 1;
  logic signed [DRIVE_SUM_BITS-1:0] drive_sum;
  logic [apr_pkg::DRIVE_BITS-1:0]   drive_next;
  logic                             sat_next;

  assign drive_sum = $signed(DRIVE_SUM_BITS'(target_code)) + DRIVE_SUM_BITS'(err);

  always_comb begin
    if (drive_sum > $signed(DRIVE_SUM_BITS'(apr_pkg::OUTPUT_MAX))) begin
      drive_next = apr_pkg::DRIVE_BITS'(apr_pkg::OUTPUT_MAX);
      sat_next   = 1'b1;
    end else if (drive_sum < 0) begin
      drive_next = '0;
      sat_next   = 1'b1;
    end else begin
      drive_next = drive_sum[apr_pkg::DRIVE_BITS-1:0];
      sat_next   = 1'b0;
    end
  end

  // Sequencer: next state and controls
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    in_take    = 1'b0;
    div_step   = 1'b0;
    mul_load   = 1'b0;
    err_load   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      apr_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        in_take  = s_tvalid;
        if (s_tvalid && batch_end) begin
          state_next = apr_pkg::ST_DIV;
        end
      end
      apr_pkg::ST_DIV: begin
        div_step = 1'b1;
        if (div_cnt == '0) begin
          state_next = apr_pkg::ST_MUL;
        end
      end
      apr_pkg::ST_MUL: begin
        mul_load   = 1'b1;
        state_next = apr_pkg::ST_ERR;
      end
      apr_pkg::ST_ERR: begin
        err_load   = 1'b1;
        state_next = apr_pkg::ST_DRIVE;
      end
      apr_pkg::ST_DRIVE: begin
        // hold here while an earlier result still waits
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = apr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = apr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      target_code   <= '0;
      gain_q8_8     <= '0;
      average_count <= apr_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        apr_pkg::REG_TARGET: target_code   <= cfg_wdata[apr_pkg::TARGET_BITS-1:0];
        apr_pkg::REG_GAIN:   gain_q8_8     <= cfg_wdata[apr_pkg::GAIN_BITS-1:0];
        apr_pkg::REG_COUNT:  average_count <= cfg_wdata[apr_pkg::COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Accumulator; cleared once the batch result is in the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_tally <= '0;
    end else if (in_take) begin
      sample_sum   <= sum_new;
      sample_tally <= tally_new;
    end else if (out_load) begin
      sample_sum   <= '0;
      sample_tally <= '0;
    end
  end

  // Divider: upper sum bits seed the remainder, lower bits shift out as quotient comes in
  always_ff @(posedge clk) begin
    if (in_take) begin
      div_rem  <= sum_new[apr_pkg::SUM_BITS-1 -: apr_pkg::TALLY_BITS];
      div_quo  <= sum_new[apr_pkg::SAMPLE_BITS-1:0];
      div_cnt  <= apr_pkg::DIV_CNT_BITS'(apr_pkg::SAMPLE_BITS - 1);
      div_zero <= (tally_new == '0);
    end else if (div_step) begin
      div_rem  <= div_ok ? div_trial[apr_pkg::TALLY_BITS-1:0]
                         : {div_rem[apr_pkg::TALLY_BITS-2:0],
                            div_quo[apr_pkg::SAMPLE_BITS-1]};
      div_quo  <= {div_quo[apr_pkg::SAMPLE_BITS-2:0], div_ok};
      div_cnt  <= div_cnt - apr_pkg::DIV_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mul_load) begin
      prod <= $signed({1'b0, gain_q8_8}) * diff;
    end
    if (err_load) begin
      err <= err_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_drive <= drive_next;
      out_mean  <= apr_pkg::MEAN_BITS'(mean);
      out_err   <= err;
      out_sat   <= sat_next;
    end
  end

  assign m_tdata = {{(apr_pkg::OUT_DATA_BITS - apr_pkg::ERR_BITS - apr_pkg::MEAN_BITS
                      - apr_pkg::DRIVE_BITS){1'b0}},
                    out_err, out_mean, out_drive};
  assign m_tuser = out_sat;

  // Assertions
  a_drive_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_drive <= apr_pkg::DRIVE_BITS'(apr_pkg::OUTPUT_MAX)))
    else $error("drive_code above the output limit");

  a_sat_at_bound: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_sat) |->
      (out_drive == '0 || out_drive == apr_pkg::DRIVE_BITS'(apr_pkg::OUTPUT_MAX)))
    else $error("clamp flag set with drive_code off the bounds");

  a_div_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == apr_pkg::ST_DIV && !div_zero) |-> (div_rem < sample_tally))
    else $error("divider remainder not below the tally");

  a_busy_after_batch: assert property (@(posedge clk) disable iff (rst)
    (state == apr_pkg::ST_DIV && div_cnt == '0) |=> (state == apr_pkg::ST_MUL && !s_tready))
    else $error("sequencer left the divide without the multiply step");

endmodule
